// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is high.
`define RPP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Overlapping implication, sampled on the rising clock edge.
`define RPP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rpp_pkg.sv -----
`default_nettype none

package rpp_pkg;

   typedef enum logic [3:0] {
      ERR_NONE    = 4'd0,
      ERR_LENGTH  = 4'd1,
      ERR_COMMAND = 4'd2,
      ERR_VERSION = 4'd3,
      ERR_ZERO    = 4'd4,
      ERR_FAMILY  = 4'd5,
      ERR_TAG     = 4'd6,
      ERR_METRIC  = 4'd7,
      ERR_MASK    = 4'd8,
      ERR_ENTRIES = 4'd9,
      ERR_TRUNC   = 4'd10
   } error_code_type;

   localparam logic KIND_ROUTE   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic           item_kind;
      logic [31:0]    route_address;
      logic [31:0]    route_mask;
      logic [31:0]    route_next_hop;
      logic [4:0]     route_metric;
      logic [7:0]     rip_command;
      logic [4:0]     entry_count;
      logic           packet_valid;
      error_code_type error_code;
      logic           last_of_run;
   } rsp_item_type;

   // Results of one accepted byte: a route item, a verdict, or both in order.
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

`default_nettype wire

// ----- rtl/rip_packet_parser.sv -----
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   packet_byte, is_last
// rsp_      out        rsp_valid/rsp_ready   route entry or packet verdict
//
// One byte is taken per cycle while req_ready is high; its results are registered
// into a four-item output queue and show on rsp_ behind any items queued before.
// A byte yields at most two items (route and verdict on the last byte).
// req_ready drops while the queue has fewer than two free slots.
// Synchronous active-high reset clears the parse state and empties the queue.
`default_nettype none
`include "assert_macros.svh"

module rip_packet_parser #(
   parameter int unsigned MAX_ENTRIES = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_packet_byte,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_item_kind,
   output logic [31:0]      rsp_route_address,
   output logic [31:0]      rsp_route_mask,
   output logic [31:0]      rsp_route_next_hop,
   output logic [4:0]       rsp_route_metric,
   output logic [7:0]       rsp_rip_command,
   output logic [4:0]       rsp_entry_count,
   output logic             rsp_packet_valid,
   output logic [3:0]       rsp_error_code,
   output logic             rsp_last_of_run
);

   rpp_pkg::push_type            push;
   rpp_pkg::rsp_item_type        head;
   logic [rpp_pkg::LEVEL_W-1:0]  level;
   logic                         take;
   logic                         pop;

   assign req_ready = (level <= rpp_pkg::LEVEL_W'(rpp_pkg::QUEUE_DEPTH - 2));
   assign take      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   rpp_parser #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .packet_byte (req_packet_byte),
      .is_last     (req_is_last),
      .push        (push)
   );

   rpp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (rsp_valid),
      .level      (level)
   );

   assign rsp_item_kind      = head.item_kind;
   assign rsp_route_address  = head.route_address;
   assign rsp_route_mask     = head.route_mask;
   assign rsp_route_next_hop = head.route_next_hop;
   assign rsp_route_metric   = head.route_metric;
   assign rsp_rip_command    = head.rip_command;
   assign rsp_entry_count    = head.entry_count;
   assign rsp_packet_valid   = head.packet_valid;
   assign rsp_error_code     = head.error_code;
   assign rsp_last_of_run    = head.last_of_run;

   `RPP_ASSERT(a_level_bound, clock, reset, level <= rpp_pkg::LEVEL_W'(rpp_pkg::QUEUE_DEPTH), "queue overflow")
   `RPP_ASSERT_IMPLY(a_verdict_flag, clock, reset, rsp_valid && rsp_item_kind == rpp_pkg::KIND_VERDICT, rsp_last_of_run && (rsp_packet_valid == (rsp_error_code == rpp_pkg::ERR_NONE)), "bad verdict flags")
   `RPP_ASSERT_IMPLY(a_route_fields, clock, reset, rsp_valid && rsp_item_kind == rpp_pkg::KIND_ROUTE, rsp_route_metric != 5'd0 && rsp_route_metric <= 5'd16 && !rsp_packet_valid && rsp_error_code == rpp_pkg::ERR_NONE, "bad route item")
   `RPP_ASSERT_IMPLY(a_route_then_verdict, clock, reset, rsp_valid && !rsp_last_of_run, level >= rpp_pkg::LEVEL_W'(2), "route without verdict behind it")

endmodule

`default_nettype wire

// ----- rtl/rpp_out_queue.sv -----
`default_nettype none

module rpp_out_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rpp_pkg::push_type             push,
   input  wire logic                          pop,
   output rpp_pkg::rsp_item_type              head,
   output logic                               head_valid,
   output logic [rpp_pkg::LEVEL_W-1:0]        level
);

   rpp_pkg::rsp_item_type mem_ff [rpp_pkg::QUEUE_DEPTH];

   logic [rpp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rpp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rpp_pkg::LEVEL_W-1:0]     level_ff, level_in;
   logic [rpp_pkg::LEVEL_W-1:0]     n_push;
   logic [rpp_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;

   assign n_push = rpp_pkg::LEVEL_W'(push.first_valid)
                 + rpp_pkg::LEVEL_W'(push.second_valid);
   assign wr_ptr_next = wr_ptr_ff + rpp_pkg::QUEUE_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + n_push[rpp_pkg::QUEUE_PTR_W-1:0];
   assign rd_ptr_in   = rd_ptr_ff + rpp_pkg::QUEUE_PTR_W'(pop);
   assign level_in    = level_ff + n_push - rpp_pkg::LEVEL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (level_ff != '0);
   assign level      = level_ff;

endmodule

`default_nettype wire

// ----- rtl/rpp_parser.sv -----
`default_nettype none

module rpp_parser #(
   parameter int unsigned MAX_ENTRIES = 25
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [7:0]        packet_byte,
   input  wire logic              is_last,
   output rpp_pkg::push_type      push
);

   localparam logic [15:0] OFS_LENGTH_HI = 16'd2;
   localparam logic [15:0] OFS_LENGTH_LO = 16'd3;
   localparam logic [15:0] OFS_COMMAND   = 16'd28;
   localparam logic [15:0] OFS_VERSION   = 16'd29;
   localparam logic [15:0] OFS_ZERO_A    = 16'd30;
   localparam logic [15:0] OFS_ZERO_B    = 16'd31;
   localparam logic [15:0] OFS_ENTRIES   = 16'd32;
   localparam logic [15:0] OFS_MAX       = 16'hFFFF;
   localparam logic [16:0] MIN_LENGTH    = 17'd4;
   localparam logic [16:0] MIN_HEADER    = 17'd32;

   localparam logic [4:0] IDX_FAMILY    = 5'd1;
   localparam logic [4:0] IDX_TAG_FIRST = 5'd2;
   localparam logic [4:0] IDX_TAG_LAST  = 5'd3;
   localparam logic [4:0] IDX_ADDR      = 5'd4;
   localparam logic [4:0] IDX_MASK      = 5'd8;
   localparam logic [4:0] IDX_HOP       = 5'd12;
   localparam logic [4:0] IDX_METRIC    = 5'd16;
   localparam logic [4:0] IDX_LAST      = 5'd19;
   localparam logic [4:0] MAX_SEEN      = 5'(MAX_ENTRIES);

   localparam logic [7:0] CMD_REQUEST     = 8'd1;
   localparam logic [7:0] CMD_RESPONSE    = 8'd2;
   localparam logic [7:0] RIP_VERSION     = 8'd2;
   localparam logic [7:0] FAMILY_REQUEST  = 8'd0;
   localparam logic [7:0] FAMILY_RESPONSE = 8'd2;
   localparam logic [31:0] METRIC_MAX     = 32'd16;

   typedef struct packed {
      logic [15:0]             offset;
      logic [15:0]             total_length;
      logic [7:0]              command;
      logic [4:0]              entry_index;
      logic                    entry_active;
      logic [7:0]              family_low;
      logic                    tag_nonzero;
      logic [31:0]             address;
      logic [31:0]             mask;
      logic [31:0]             next_hop;
      logic [31:0]             metric;
      logic [4:0]              entries_seen;
      rpp_pkg::error_code_type failure;
   } parse_state_type;

   parse_state_type         state_ff, state_in;
   logic [4:0]              idx;
   logic [31:0]             mask_inv;
   logic                    family_ok;
   logic                    metric_ok;
   logic                    mask_ok;
   rpp_pkg::error_code_type entry_code;
   rpp_pkg::error_code_type verdict_code;
   logic                    route_hit;
   logic [16:0]             count;
   rpp_pkg::rsp_item_type   route_item;
   rpp_pkg::rsp_item_type   verdict_item;

   always_comb begin
      state_in     = state_ff;
      idx          = '0;
      mask_inv     = '0;
      family_ok    = 1'b0;
      metric_ok    = 1'b0;
      mask_ok      = 1'b0;
      entry_code   = rpp_pkg::ERR_NONE;
      verdict_code = rpp_pkg::ERR_NONE;
      route_hit    = 1'b0;
      count        = {1'b0, state_ff.offset} + 17'd1;

      if (state_ff.offset == OFS_LENGTH_HI) begin
         state_in.total_length[15:8] = packet_byte;
      end else if (state_ff.offset == OFS_LENGTH_LO) begin
         state_in.total_length[7:0] = packet_byte;
      end else if (state_ff.offset == OFS_COMMAND) begin
         state_in.command = packet_byte;
      end

      if (state_ff.failure == rpp_pkg::ERR_NONE) begin
         if (state_ff.offset == OFS_COMMAND && packet_byte != CMD_REQUEST
             && packet_byte != CMD_RESPONSE) begin
            state_in.failure = rpp_pkg::ERR_COMMAND;
         end else if (state_ff.offset == OFS_VERSION && packet_byte != RIP_VERSION) begin
            state_in.failure = rpp_pkg::ERR_VERSION;
         end else if ((state_ff.offset == OFS_ZERO_A || state_ff.offset == OFS_ZERO_B)
                      && packet_byte != 8'd0) begin
            state_in.failure = rpp_pkg::ERR_ZERO;
         end else if (state_ff.offset >= OFS_ENTRIES) begin
            if (!state_ff.entry_active && state_ff.offset < state_in.total_length) begin
               if (state_ff.entries_seen >= MAX_SEEN) begin
                  state_in.failure = rpp_pkg::ERR_ENTRIES;
               end else begin
                  state_in.entries_seen = state_ff.entries_seen + 5'd1;
                  state_in.entry_active = 1'b1;
                  state_in.entry_index  = '0;
                  state_in.tag_nonzero  = 1'b0;
                  state_in.family_low   = '0;
               end
            end
            if (state_in.entry_active) begin
               idx = state_in.entry_index;
               if (idx == IDX_FAMILY) begin
                  state_in.family_low = packet_byte;
               end else if (idx inside {[IDX_TAG_FIRST:IDX_TAG_LAST]}) begin
                  state_in.tag_nonzero = state_in.tag_nonzero | (packet_byte != 8'd0);
               end else if (idx inside {[IDX_ADDR:IDX_MASK-5'd1]}) begin
                  state_in.address = {state_in.address[23:0], packet_byte};
               end else if (idx inside {[IDX_MASK:IDX_HOP-5'd1]}) begin
                  state_in.mask = {state_in.mask[23:0], packet_byte};
               end else if (idx inside {[IDX_HOP:IDX_METRIC-5'd1]}) begin
                  state_in.next_hop = {state_in.next_hop[23:0], packet_byte};
               end else if (idx >= IDX_METRIC) begin
                  state_in.metric = {state_in.metric[23:0], packet_byte};
               end

               if (idx >= IDX_LAST) begin
                  family_ok = (state_in.command == CMD_REQUEST
                               && state_in.family_low == FAMILY_REQUEST)
                           || (state_in.command == CMD_RESPONSE
                               && state_in.family_low == FAMILY_RESPONSE);
                  metric_ok = (state_in.metric != 32'd0) && (state_in.metric <= METRIC_MAX);
                  mask_inv  = ~state_in.mask;
                  mask_ok   = ((mask_inv & (mask_inv + 32'd1)) == 32'd0);
                  if (!family_ok) begin
                     entry_code = rpp_pkg::ERR_FAMILY;
                  end else if (state_in.tag_nonzero) begin
                     entry_code = rpp_pkg::ERR_TAG;
                  end else if (!metric_ok) begin
                     entry_code = rpp_pkg::ERR_METRIC;
                  end else if (!mask_ok) begin
                     entry_code = rpp_pkg::ERR_MASK;
                  end
                  state_in.entry_active = 1'b0;
                  state_in.entry_index  = '0;
                  if (entry_code != rpp_pkg::ERR_NONE) begin
                     state_in.failure = entry_code;
                  end else begin
                     route_hit = 1'b1;
                  end
               end else begin
                  state_in.entry_index = idx + 5'd1;
               end
            end
         end
      end

      if (state_ff.offset != OFS_MAX) begin
         state_in.offset = state_ff.offset + 16'd1;
      end

      if (count < MIN_LENGTH) begin
         verdict_code = rpp_pkg::ERR_TRUNC;
      end else if ({1'b0, state_in.total_length} > count) begin
         verdict_code = rpp_pkg::ERR_LENGTH;
      end else if (state_in.failure != rpp_pkg::ERR_NONE) begin
         verdict_code = state_in.failure;
      end else if (count < MIN_HEADER || state_in.entry_active) begin
         verdict_code = rpp_pkg::ERR_TRUNC;
      end

      route_item.item_kind      = rpp_pkg::KIND_ROUTE;
      route_item.route_address  = state_in.address;
      route_item.route_mask     = state_in.mask;
      route_item.route_next_hop = state_in.next_hop;
      route_item.route_metric   = state_in.metric[4:0];
      route_item.rip_command    = state_in.command;
      route_item.entry_count    = state_in.entries_seen;
      route_item.packet_valid   = 1'b0;
      route_item.error_code     = rpp_pkg::ERR_NONE;
      route_item.last_of_run    = !is_last;

      verdict_item.item_kind      = rpp_pkg::KIND_VERDICT;
      verdict_item.route_address  = '0;
      verdict_item.route_mask     = '0;
      verdict_item.route_next_hop = '0;
      verdict_item.route_metric   = '0;
      verdict_item.rip_command    = state_in.command;
      verdict_item.entry_count    = state_in.entries_seen;
      verdict_item.packet_valid   = (verdict_code == rpp_pkg::ERR_NONE);
      verdict_item.error_code     = verdict_code;
      verdict_item.last_of_run    = 1'b1;

      // packet done: back to the idle state for the next one
      if (is_last) begin
         state_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   assign push.first_valid  = take && (route_hit || is_last);
   assign push.second_valid = take && route_hit && is_last;
   assign push.first        = route_hit ? route_item : verdict_item;
   assign push.second       = verdict_item;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int MAX_ENTRIES = 25;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BYTES_PER_PHASE = 60;

   typedef enum int {
      FLT_COMMAND,
      FLT_VERSION,
      FLT_ZERO,
      FLT_FAMILY,
      FLT_TAG,
      FLT_METRIC,
      FLT_MASK,
      FLT_LENGTH,
      FLT_CUT,
      FLT_TRAIL
   } fault_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } link_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_packet_byte = 8'd0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_item_kind;
   logic [31:0] rsp_route_address;
   logic [31:0] rsp_route_mask;
   logic [31:0] rsp_route_next_hop;
   logic [4:0]  rsp_route_metric;
   logic [7:0]  rsp_rip_command;
   logic [4:0]  rsp_entry_count;
   logic        rsp_packet_valid;
   logic [3:0]  rsp_error_code;
   logic        rsp_last_of_run;

   rip_packet_parser #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_packet_byte(req_packet_byte),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item_kind(rsp_item_kind),
      .rsp_route_address(rsp_route_address),
      .rsp_route_mask(rsp_route_mask),
      .rsp_route_next_hop(rsp_route_next_hop),
      .rsp_route_metric(rsp_route_metric),
      .rsp_rip_command(rsp_rip_command),
      .rsp_entry_count(rsp_entry_count),
      .rsp_packet_valid(rsp_packet_valid),
      .rsp_error_code(rsp_error_code),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   link_byte_type         byte_queue [$];
   rpp_pkg::rsp_item_type route_and_verdict_q [$];
   logic [7:0]            frame [$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned mismatches = 0;
   int unsigned packets_sent = 0;
   int unsigned bytes_queued = 0;
   int unsigned routes_ok = 0;
   int unsigned verdicts_ok = 0;
   int unsigned idle_cycles = 0;

   // parser shadow state
   logic [15:0]             parse_pos;
   logic [15:0]             len_field;
   logic [7:0]              cmd_seen;
   logic [7:0]              fam_low;
   logic [4:0]              ent_idx;
   logic [4:0]              ent_count;
   logic                    ent_open;
   logic                    tag_bad;
   logic [31:0]             addr_acc;
   logic [31:0]             mask_acc;
   logic [31:0]             hop_acc;
   logic [31:0]             metric_acc;
   rpp_pkg::error_code_type fail_code;

   function automatic void clear_parse();
      parse_pos = '0;
      len_field = '0;
      cmd_seen = '0;
      fam_low = '0;
      ent_idx = '0;
      ent_count = '0;
      ent_open = 1'b0;
      tag_bad = 1'b0;
      addr_acc = '0;
      mask_acc = '0;
      hop_acc = '0;
      metric_acc = '0;
      fail_code = rpp_pkg::ERR_NONE;
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic last);
      logic [15:0]             o;
      logic [31:0]             inv;
      int unsigned             count;
      rpp_pkg::error_code_type e;
      rpp_pkg::error_code_type code;
      rpp_pkg::rsp_item_type   r;
      o = parse_pos;
      if (o == 16'd2) len_field[15:8] = b;
      else if (o == 16'd3) len_field[7:0] = b;
      else if (o == 16'd28) cmd_seen = b;

      if (fail_code == rpp_pkg::ERR_NONE) begin
         if (o == 16'd28 && b != 8'd1 && b != 8'd2) begin
            fail_code = rpp_pkg::ERR_COMMAND;
         end else if (o == 16'd29 && b != 8'd2) begin
            fail_code = rpp_pkg::ERR_VERSION;
         end else if ((o == 16'd30 || o == 16'd31) && b != 8'd0) begin
            fail_code = rpp_pkg::ERR_ZERO;
         end else if (o >= 16'd32) begin
            if (!ent_open && o < len_field) begin
               if (ent_count >= MAX_ENTRIES) begin
                  fail_code = rpp_pkg::ERR_ENTRIES;
               end else begin
                  ent_count = ent_count + 5'd1;
                  ent_open = 1'b1;
                  ent_idx = '0;
                  tag_bad = 1'b0;
                  fam_low = '0;
               end
            end
            if (ent_open) begin
               if (ent_idx == 5'd1) fam_low = b;
               else if (ent_idx == 5'd2 || ent_idx == 5'd3) tag_bad |= (b != 8'd0);
               else if (ent_idx >= 5'd4 && ent_idx <= 5'd7) addr_acc = {addr_acc[23:0], b};
               else if (ent_idx >= 5'd8 && ent_idx <= 5'd11) mask_acc = {mask_acc[23:0], b};
               else if (ent_idx >= 5'd12 && ent_idx <= 5'd15) hop_acc = {hop_acc[23:0], b};
               else if (ent_idx >= 5'd16) metric_acc = {metric_acc[23:0], b};

               if (ent_idx >= 5'd19) begin
                  inv = ~mask_acc;
                  if (!((cmd_seen == 8'd1 && fam_low == 8'd0) ||
                        (cmd_seen == 8'd2 && fam_low == 8'd2)))
                     e = rpp_pkg::ERR_FAMILY;
                  else if (tag_bad)
                     e = rpp_pkg::ERR_TAG;
                  else if (metric_acc < 32'd1 || metric_acc > 32'd16)
                     e = rpp_pkg::ERR_METRIC;
                  else if ((inv & (inv + 32'd1)) != 32'd0)
                     e = rpp_pkg::ERR_MASK;
                  else
                     e = rpp_pkg::ERR_NONE;
                  ent_open = 1'b0;
                  ent_idx = '0;
                  if (e != rpp_pkg::ERR_NONE) begin
                     fail_code = e;
                  end else begin
                     r = '0;
                     r.item_kind = rpp_pkg::KIND_ROUTE;
                     r.route_address = addr_acc;
                     r.route_mask = mask_acc;
                     r.route_next_hop = hop_acc;
                     r.route_metric = metric_acc[4:0];
                     r.rip_command = cmd_seen;
                     r.entry_count = ent_count;
                     r.error_code = rpp_pkg::ERR_NONE;
                     r.last_of_run = !last;
                     route_and_verdict_q.push_back(r);
                  end
               end else begin
                  ent_idx = ent_idx + 5'd1;
               end
            end
         end
      end

      if (parse_pos != 16'hFFFF) parse_pos = parse_pos + 16'd1;

      if (last) begin
         count = 32'(o) + 32'd1;
         if (count < 4) code = rpp_pkg::ERR_TRUNC;
         else if (32'(len_field) > count) code = rpp_pkg::ERR_LENGTH;
         else if (fail_code != rpp_pkg::ERR_NONE) code = fail_code;
         else if (count < 32 || ent_open) code = rpp_pkg::ERR_TRUNC;
         else code = rpp_pkg::ERR_NONE;
         r = '0;
         r.item_kind = rpp_pkg::KIND_VERDICT;
         r.rip_command = cmd_seen;
         r.entry_count = ent_count;
         r.packet_valid = (code == rpp_pkg::ERR_NONE);
         r.error_code = code;
         r.last_of_run = 1'b1;
         route_and_verdict_q.push_back(r);
         clear_parse();
      end
   endfunction

   function automatic string fmt_result(rpp_pkg::rsp_item_type r);
      return $sformatf(
         "kind=%0d addr=%h mask=%h hop=%h metric=%0d cmd=%0d cnt=%0d ok=%0d err=%0d last=%0d",
         r.item_kind, r.route_address, r.route_mask, r.route_next_hop, r.route_metric,
         r.rip_command, r.entry_count, r.packet_valid, r.error_code, r.last_of_run);
   endfunction

   // driver
   link_byte_type nxt;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            parse_byte(req_packet_byte, req_is_last);
         if (!req_valid || req_ready) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = byte_queue.pop_front();
               req_valid <= 1'b1;
               req_packet_byte <= nxt.data;
               req_is_last <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   rpp_pkg::rsp_item_type got;
   rpp_pkg::rsp_item_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            got.item_kind = rsp_item_kind;
            got.route_address = rsp_route_address;
            got.route_mask = rsp_route_mask;
            got.route_next_hop = rsp_route_next_hop;
            got.route_metric = rsp_route_metric;
            got.rip_command = rsp_rip_command;
            got.entry_count = rsp_entry_count;
            got.packet_valid = rsp_packet_valid;
            got.error_code = rpp_pkg::error_code_type'(rsp_error_code);
            got.last_of_run = rsp_last_of_run;
            if (route_and_verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected item: %s", $time, fmt_result(got));
            end else begin
               want = route_and_verdict_q.pop_front();
               if (got.item_kind !== want.item_kind ||
                   got.route_address !== want.route_address ||
                   got.route_mask !== want.route_mask ||
                   got.route_next_hop !== want.route_next_hop ||
                   got.route_metric !== want.route_metric ||
                   got.rip_command !== want.rip_command ||
                   got.entry_count !== want.entry_count ||
                   got.packet_valid !== want.packet_valid ||
                   got.error_code !== want.error_code ||
                   got.last_of_run !== want.last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] mismatch", $time);
                     $display("   expected %s", fmt_result(want));
                     $display("   actual   %s", fmt_result(got));
                  end
               end else if (want.item_kind == rpp_pkg::KIND_ROUTE) begin
                  routes_ok++;
               end else begin
                  verdicts_ok++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // packet building
   task automatic push_word(logic [31:0] w);
      for (int i = 3; i >= 0; i--) frame.push_back(w[8*i +: 8]);
   endtask

   task automatic put_word(int at, logic [31:0] w);
      for (int i = 0; i < 4; i++) frame[at + i] = w[31 - 8*i -: 8];
   endtask

   task automatic set_length(int unsigned v);
      frame[2] = 8'(v >> 8);
      frame[3] = 8'(v);
   endtask

   task automatic build_frame(int routes, logic [7:0] cmd);
      int plen;
      frame.delete();
      for (int i = 0; i < 28; i++) frame.push_back(8'($urandom()));
      set_length(32 + 20 * routes);
      frame.push_back(cmd);
      frame.push_back(8'd2);
      frame.push_back(8'd0);
      frame.push_back(8'd0);
      for (int k = 0; k < routes; k++) begin
         frame.push_back(8'($urandom()));
         frame.push_back(cmd == 8'd1 ? 8'd0 : 8'd2);
         frame.push_back(8'd0);
         frame.push_back(8'd0);
         push_word($urandom());
         plen = $urandom_range(0, 32);
         push_word(plen == 0 ? 32'd0 : (~32'd0) << (32 - plen));
         push_word($urandom());
         push_word(32'($urandom_range(1, 16)));
      end
   endtask

   task automatic send_frame();
      link_byte_type lb;
      foreach (frame[i]) begin
         lb.data = frame[i];
         lb.last = (i == frame.size() - 1);
         byte_queue.push_back(lb);
      end
      bytes_queued += frame.size();
      packets_sent++;
   endtask

   task automatic wait_drain();
      while (byte_queue.size() != 0 || req_valid || route_and_verdict_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int unsigned    phase_start;
      int             p;
      int             routes;
      int             k;
      int             n;
      int             pick;
      logic [7:0]     cmd;
      fault_kind_type fault;

      clear_parse();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // runts and header-only packets
      build_frame(0, 8'd1); frame = frame[0:0]; send_frame();
      build_frame(0, 8'd2); frame = frame[0:2]; send_frame();
      build_frame(0, 8'd1); set_length(4); frame = frame[0:3]; send_frame();
      build_frame(0, 8'd1); set_length(20); frame = frame[0:19]; send_frame();
      build_frame(0, 8'd2); send_frame();
      // field extremes
      build_frame(1, 8'd1);
      put_word(36, 32'd0); put_word(40, 32'd0); put_word(44, 32'd0); put_word(48, 32'd1);
      send_frame();
      build_frame(2, 8'd2);
      put_word(36, '1); put_word(40, '1); put_word(44, '1); put_word(48, 32'd16);
      put_word(60, 32'hFFFF_FF00);
      send_frame();
      // one error per check
      build_frame(1, 8'd2); set_length(53); send_frame();
      build_frame(0, 8'd1); frame[28] = 8'd0; send_frame();
      build_frame(0, 8'd2); frame[28] = 8'hFF; send_frame();
      build_frame(0, 8'd1); frame[29] = 8'd1; send_frame();
      build_frame(0, 8'd2); frame[30] = 8'h80; send_frame();
      build_frame(0, 8'd2); frame[31] = 8'h01; send_frame();
      build_frame(1, 8'd1); frame[33] = 8'd2; send_frame();
      build_frame(1, 8'd2); frame[35] = 8'h01; send_frame();
      build_frame(1, 8'd1); put_word(48, 32'd0); send_frame();
      build_frame(1, 8'd2); put_word(48, 32'd17); send_frame();
      build_frame(1, 8'd2); put_word(40, 32'hFF00_FF00); send_frame();
      // entry limit: the last allowed entry passes, the one after it fails
      build_frame(MAX_ENTRIES, 8'd2); set_length(33 + 20 * MAX_ENTRIES);
      frame.push_back(8'($urandom()));
      send_frame();
      // ends inside an entry
      build_frame(2, 8'd1); set_length(33); frame = frame[0:44]; send_frame();
      // entry runs past the total length
      build_frame(1, 8'd1); set_length(33); send_frame();
      // trailing bytes after the last entry
      build_frame(1, 8'd2);
      repeat (12) frame.push_back(8'($urandom()));
      send_frame();
      wait_drain();

      p = 0;
      while (p < 4) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < RANDOM_BYTES_PER_PHASE) begin
            routes = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
            cmd = 8'($urandom_range(1, 2));
            build_frame(routes, cmd);
            pick = $urandom_range(0, 99);
            if (pick >= 60 && pick < 70) begin
               // noise
               frame.delete();
               n = $urandom_range(1, 64);
               repeat (n) frame.push_back(8'($urandom()));
            end else if (pick >= 70) begin
               fault = fault_kind_type'($urandom_range(0, 9));
               k = (routes > 0) ? 32 + 20 * $urandom_range(0, routes - 1) : 0;
               case (fault)
                  FLT_COMMAND: frame[28] = 8'(2 + $urandom_range(1, 254));
                  FLT_VERSION: frame[29] = 8'(2 + $urandom_range(1, 255));
                  FLT_ZERO:    frame[30 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
                  FLT_FAMILY:  if (routes > 0) frame[k + 1] ^= 8'($urandom_range(1, 255));
                  FLT_TAG:     if (routes > 0)
                                  frame[k + 2 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
                  FLT_METRIC:  if (routes > 0)
                                  put_word(k + 16, ($urandom_range(0, 1) == 0) ?
                                           32'($urandom_range(0, 1) * 17) : ($urandom() | 32'h100));
                  FLT_MASK:    if (routes > 0)
                                  put_word(k + 8, ($urandom() & 32'h7FFF_FFFF) | 32'd1);
                  FLT_LENGTH:  set_length(frame.size() + $urandom_range(1, 300));
                  FLT_CUT: begin
                     n = $urandom_range(1, frame.size() - 1);
                     if ($urandom_range(0, 1)) set_length($urandom_range(0, n));
                     frame = frame[0:n-1];
                  end
                  default: begin
                     repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom()));
                     if (routes > 0 && $urandom_range(0, 1))
                        set_length(32 + 20 * (routes - 1) + $urandom_range(1, 19));
                  end
               endcase
            end
            if ($urandom_range(0, 7) == 0) wait_drain();
            send_frame();
         end
         wait_drain();
         p++;
      end

      wait_drain();
      repeat (8) @(negedge clock);
      if (route_and_verdict_q.size() != 0) begin
         $display("%0d expected items never arrived", route_and_verdict_q.size());
         mismatches++;
      end
      $display("Sent %0d packets (%0d bytes): runts, every error code, entry limit, trailers.",
               packets_sent, bytes_queued);
      $display("Checked %0d routes and %0d verdicts under four pacings; %0d mismatches.",
               routes_ok, verdicts_ok, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
